// File: sv/swc_pkg.sv
// Shared types and constants for the set-associative write-back cache.
`timescale 1ns / 1ps
`default_nettype none
package swc_pkg;
	localparam int LINES = 64;
	localparam int LINE_W = 6;
	localparam int TAG_W = 11;
	localparam int STAMP_W = 32;
	localparam int WAY_W = 3;
	localparam int MAX_WAYS = 8;
	localparam int MAX_SET_BITS = 6;
	localparam int MIN_OFF_BITS = 2;
	localparam int ADDR_W = 13;
	localparam int PADDR_W = 5;

	localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
	localparam logic [2:0] REG_SET_BITS = 3'd1;
	localparam logic [2:0] REG_WAYS = 3'd2;
	localparam logic [2:0] REG_HIT_COST = 3'd3;
	localparam logic [2:0] REG_MISS_COST = 3'd4;

	localparam logic [2:0] RST_OFFSET_BITS = 3'd4;
	localparam logic [2:0] RST_SET_BITS = 3'd3;
	localparam logic [3:0] RST_WAYS = 4'd2;
	localparam logic [15:0] RST_HIT_COST = 16'd1;
	localparam logic [15:0] RST_MISS_COST = 16'd100;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic cmp;
		logic next_way;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic hit_now;
		logic last_way;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [2:0] off;
		logic [2:0] sb;
		logic [3:0] nw;
		logic [15:0] hit_cost;
		logic [15:0] miss_cost;
	} cfg_t;
endpackage
`default_nettype wire

// File: sv/swc_ifs.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface swc_req_if;
	logic valid;
	logic ready;
	logic command;
	logic [12:0] address;
	logic [31:0] store_data;
	modport source (output valid, command, address, store_data, input ready);
	modport sink (input valid, command, address, store_data, output ready);
endinterface

interface swc_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic wrote_back;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] total_cycles;
	modport source (output valid, hit, wrote_back, hit_count, miss_count, total_cycles,
		input ready);
	modport sink (input valid, hit, wrote_back, hit_count, miss_count, total_cycles,
		output ready);
endinterface
`default_nettype wire

// File: sv/swc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module swc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: sv/swc_ctrl.sv
// Lookup sequencer: scans the ways of a set and commits the access.
`timescale 1ns / 1ps
`default_nettype none
module swc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire swc_pkg::sts_t sts,
	output swc_pkg::cmd_t cmd
);
	swc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swc_pkg::ST_IDLE: begin
				if (req_valid) state_d = swc_pkg::ST_READ;
			end
			swc_pkg::ST_READ: state_d = swc_pkg::ST_CMP;
			swc_pkg::ST_CMP: begin
				if (sts.hit_now || sts.last_way) state_d = swc_pkg::ST_COMMIT;
				else state_d = swc_pkg::ST_READ;
			end
			swc_pkg::ST_COMMIT: begin
				if (sts.out_free) state_d = swc_pkg::ST_IDLE;
			end
			default: state_d = swc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			swc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			swc_pkg::ST_READ: cmd.rd = 1'b1;
			swc_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				cmd.next_way = !(sts.hit_now || sts.last_way);
			end
			swc_pkg::ST_COMMIT: cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/swc_dp.sv
// Datapath: line metadata, victim choice, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module swc_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire swc_pkg::cfg_t cfg,
	input wire swc_pkg::cmd_t cmd,
	output swc_pkg::sts_t sts,
	input wire logic req_command,
	input wire logic [12:0] req_address,
	swc_rsp_if.source rsp
);
	localparam int META_W = swc_pkg::TAG_W + swc_pkg::STAMP_W;

	logic [2:0] off_n, sb_n;
	logic [3:0] nw_n;
	logic [swc_pkg::LINES-1:0] valid_q, dirty_q;
	logic is_store_q;
	logic [swc_pkg::TAG_W-1:0] tag_q;
	logic [swc_pkg::LINE_W-1:0] first_q, hit_line_q, lru_line_q, pick;
	logic [swc_pkg::WAY_W-1:0] way_q;
	logic [swc_pkg::STAMP_W-1:0] min_stamp_q;
	logic hit_q;
	logic [31:0] hits_q, misses_q, total_q;
	logic out_valid_q, out_hit_q, out_wb_q;
	logic [swc_pkg::LINE_W-1:0] cur_line, ram_addr;
	logic [META_W-1:0] ram_rdata;
	logic [swc_pkg::TAG_W-1:0] rd_tag;
	logic [swc_pkg::STAMP_W-1:0] rd_stamp;
	logic inv_found;
	logic [swc_pkg::LINE_W-1:0] inv_line;
	logic wb;
	logic [12:0] word_addr;
	logic [3:0] tag_sh;
	logic [12:0] set_full;
	logic [9:0] first_full;

	always_comb begin
		off_n = (cfg.off < 3'(swc_pkg::MIN_OFF_BITS)) ? 3'(swc_pkg::MIN_OFF_BITS) : cfg.off;
		nw_n = (cfg.nw == 4'd0) ? 4'd1 :
			(cfg.nw > 4'(swc_pkg::MAX_WAYS)) ? 4'(swc_pkg::MAX_WAYS) : cfg.nw;
		sb_n = (cfg.sb > 3'(swc_pkg::MAX_SET_BITS)) ? 3'(swc_pkg::MAX_SET_BITS) : cfg.sb;
		for (int s = swc_pkg::MAX_SET_BITS; s > 0; s--) begin
			if (sb_n == 3'(s) && (11'(nw_n) << s) > 11'(swc_pkg::LINES)) sb_n = 3'(s - 1);
		end
	end

	assign word_addr = req_address & 13'h1ffc;
	assign set_full = (word_addr >> off_n) & ((13'd1 << sb_n) - 13'd1);
	assign tag_sh = 4'(off_n) + 4'(sb_n);
	assign first_full = 10'(set_full[5:0]) * 10'(nw_n);

	assign cur_line = first_q + swc_pkg::LINE_W'(way_q);
	assign rd_tag = ram_rdata[META_W-1 -: swc_pkg::TAG_W];
	assign rd_stamp = ram_rdata[swc_pkg::STAMP_W-1:0];

	always_comb begin
		inv_found = 1'b0;
		inv_line = first_q;
		for (int w = swc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
			if (4'(w) < nw_n && !valid_q[first_q + swc_pkg::LINE_W'(w)]) begin
				inv_found = 1'b1;
				inv_line = first_q + swc_pkg::LINE_W'(w);
			end
		end
	end

	assign pick = hit_q ? hit_line_q : (inv_found ? inv_line : lru_line_q);
	assign wb = !hit_q && !inv_found && dirty_q[lru_line_q];
	assign ram_addr = cmd.commit ? pick : cur_line;

	swc_ram #(.WIDTH(META_W), .DEPTH(swc_pkg::LINES)) u_meta (
		.clk(clk),
		.we(cmd.commit),
		.addr(ram_addr),
		.wdata({tag_q, total_q}),
		.rdata(ram_rdata)
	);

	assign sts.hit_now = cmd.cmp && valid_q[cur_line] && rd_tag == tag_q;
	assign sts.last_way = (4'(way_q) + 4'd1) >= nw_n;
	assign sts.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_store_q <= req_command;
			tag_q <= swc_pkg::TAG_W'(word_addr >> tag_sh);
			first_q <= first_full[swc_pkg::LINE_W-1:0];
			way_q <= '0;
			hit_q <= 1'b0;
		end
		if (cmd.cmp) begin
			if (sts.hit_now) begin
				hit_q <= 1'b1;
				hit_line_q <= cur_line;
			end
			if (way_q == '0 || rd_stamp < min_stamp_q) begin
				min_stamp_q <= rd_stamp;
				lru_line_q <= cur_line;
			end
		end
		if (cmd.next_way) way_q <= way_q + 1'b1;
		if (cmd.commit) begin
			out_hit_q <= hit_q;
			out_wb_q <= wb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			hits_q <= '0;
			misses_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) out_valid_q <= 1'b0;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				valid_q[pick] <= 1'b1;
				dirty_q[pick] <= is_store_q || (hit_q && dirty_q[pick]);
				if (hit_q) begin
					hits_q <= hits_q + 32'd1;
					total_q <= total_q + 32'(cfg.hit_cost);
				end else begin
					misses_q <= misses_q + 32'd1;
					total_q <= total_q + 32'(cfg.miss_cost);
				end
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit = out_hit_q;
	assign rsp.wrote_back = out_wb_q;
	assign rsp.hit_count = hits_q;
	assign rsp.miss_count = misses_q;
	assign rsp.total_cycles = total_q;

`ifndef SYNTH
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free) else $error("commit with result slot busy");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q) else $error("result not registered");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (hits_q + misses_q) == ($past(hits_q + misses_q) + 32'd1))
		else $error("access counters out of step");
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> !out_wb_q) else $error("write-back on hit");
`endif
endmodule
`default_nettype wire

// File: sv/set_assoc_writeback_cache.sv
// Top level of the set-associative write-back write-allocate LRU cache.
// Requests: one at a time; the way-by-way tag scan through the
// single-port metadata RAM paces them.
// Reset: asynchronous; clears line valid/dirty bits, counters, the result valid flag, config registers and FSM state.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_writeback_cache (
	input wire logic clk,
	input wire logic arst_n,
	swc_req_if.sink req,
	swc_rsp_if.source rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [swc_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	swc_pkg::cfg_t cfg_q;
	swc_pkg::cmd_t cmd;
	swc_pkg::sts_t sts;
	logic [2:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off <= swc_pkg::RST_OFFSET_BITS;
			cfg_q.sb <= swc_pkg::RST_SET_BITS;
			cfg_q.nw <= swc_pkg::RST_WAYS;
			cfg_q.hit_cost <= swc_pkg::RST_HIT_COST;
			cfg_q.miss_cost <= swc_pkg::RST_MISS_COST;
		end else if (wr_en) begin
			case (reg_idx)
				swc_pkg::REG_OFFSET_BITS: cfg_q.off <= pwdata[2:0];
				swc_pkg::REG_SET_BITS: cfg_q.sb <= pwdata[2:0];
				swc_pkg::REG_WAYS: cfg_q.nw <= pwdata[3:0];
				swc_pkg::REG_HIT_COST: cfg_q.hit_cost <= pwdata[15:0];
				swc_pkg::REG_MISS_COST: cfg_q.miss_cost <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			swc_pkg::REG_OFFSET_BITS: prdata = 32'(cfg_q.off);
			swc_pkg::REG_SET_BITS: prdata = 32'(cfg_q.sb);
			swc_pkg::REG_WAYS: prdata = 32'(cfg_q.nw);
			swc_pkg::REG_HIT_COST: prdata = 32'(cfg_q.hit_cost);
			swc_pkg::REG_MISS_COST: prdata = 32'(cfg_q.miss_cost);
			default: prdata = '0;
		endcase
	end

	swc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts(sts),
		.cmd(cmd)
	);

	swc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.sts(sts),
		.req_command(req.command),
		.req_address(req.address),
		.rsp(rsp)
	);
endmodule
`default_nettype wire
